// ----- rtl/epfm_pkg.sv -----
// Package for the edge period and frequency meter.
// Holds widths, constants, the sequencer state type and control structs.
// No dependencies.
`timescale 1ns / 1ps

package epfm_pkg;

  // Default counter and wrap-count widths
  localparam int COUNTER_BITS_DEF = 32;
  localparam int WRAP_BITS_DEF    = 8;

  // Field widths
  localparam int CAP_W  = 32;
  localparam int CLK_W  = 8;
  localparam int PER_W  = 40;
  localparam int NS_W   = 50;
  localparam int FQ_W   = 38;

  // Shared divider sizing
  localparam int DIV_NUM_W = NS_W;
  localparam int DIV_DEN_W = PER_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Constants
  localparam logic [CLK_W-1:0] CLK_MHZ_RESET   = 8'd48;
  localparam logic [FQ_W-1:0]  MILLIHZ_PER_MHZ = 38'd1000000000;

  // Input kind carried in tuser
  localparam logic CMD_WRAP = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NS_GO,
    ST_NS_RUN,
    ST_FQ_GO,
    ST_FQ_RUN,
    ST_DONE
  } epfm_state_e;

  // Sequencer -> datapath controls
  typedef struct packed {
    logic in_ready;
    logic clr_res;
    logic div_start;
    logic div_fq;
    logic cap_ns;
    logic cap_fq;
    logic load_out;
  } epfm_ctrl_t;

  // Datapath -> sequencer status
  typedef struct packed {
    logic in_fire;
    logic div_done;
    logic clk_zero;
    logic per_zero;
    logic out_free;
  } epfm_stat_t;

endpackage

// ----- rtl/epfm_div.sv -----
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on epfm_pkg for default widths.
`timescale 1ns / 1ps

module epfm_div #(
  parameter int NUM_W = epfm_pkg::DIV_NUM_W,
  parameter int DEN_W = epfm_pkg::DIV_DEN_W,
  parameter int CNT_W = epfm_pkg::DIV_CNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,    // dividend, left aligned
  input  logic [DEN_W-1:0] den_i,
  input  logic [CNT_W-1:0] steps_i,  // number of quotient bits to produce
  output logic [NUM_W-1:0] quot_o,   // quotient in the low steps_i bits
  output logic             done_o
);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] sr_q, sr_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_q, sr_q[NUM_W-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    if (fits) begin
      rem_d = DEN_W'(rem_sh - {1'b0, den_q});
    end else begin
      rem_d = rem_sh[DEN_W-1:0];
    end
    sr_d = {sr_q[NUM_W-2:0], fits};
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sr_q  <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sr_q  <= sr_d;
    end
  end

  assign quot_o = sr_q;
  assign done_o = done_q;

endmodule

// ----- rtl/epfm_seq.sv -----
// Sequencer for the meter: runs the ns division then the frequency division.
// Depends on epfm_pkg for state and control types.
`timescale 1ns / 1ps

module epfm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  epfm_pkg::epfm_stat_t stat_i,
  output epfm_pkg::epfm_ctrl_t ctrl_o
);

  epfm_pkg::epfm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= epfm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      epfm_pkg::ST_IDLE: begin
        if (stat_i.in_fire) state_d = epfm_pkg::ST_NS_GO;
      end
      epfm_pkg::ST_NS_GO: begin
        state_d = stat_i.clk_zero ? epfm_pkg::ST_DONE : epfm_pkg::ST_NS_RUN;
      end
      epfm_pkg::ST_NS_RUN: begin
        if (stat_i.div_done) begin
          state_d = stat_i.per_zero ? epfm_pkg::ST_DONE : epfm_pkg::ST_FQ_GO;
        end
      end
      epfm_pkg::ST_FQ_GO: begin
        state_d = epfm_pkg::ST_FQ_RUN;
      end
      epfm_pkg::ST_FQ_RUN: begin
        if (stat_i.div_done) state_d = epfm_pkg::ST_DONE;
      end
      epfm_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = epfm_pkg::ST_IDLE;
      end
      default: state_d = epfm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      epfm_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
      end
      epfm_pkg::ST_NS_GO: begin
        ctrl_o.clr_res   = 1'b1;
        ctrl_o.div_start = !stat_i.clk_zero;
      end
      epfm_pkg::ST_NS_RUN: begin
        ctrl_o.cap_ns = stat_i.div_done;
      end
      epfm_pkg::ST_FQ_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_fq    = 1'b1;
      end
      epfm_pkg::ST_FQ_RUN: begin
        ctrl_o.div_fq = 1'b1;
        ctrl_o.cap_fq = stat_i.div_done;
      end
      epfm_pkg::ST_DONE: begin
        ctrl_o.load_out = stat_i.out_free;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

// ----- rtl/edge_period_frequency_meter.sv -----
// Top level of the edge period and frequency meter.
// Depends on epfm_pkg, epfm_seq and epfm_div.
`timescale 1ns / 1ps

// Usage:
//   Input stream: tuser = command (0 wrap, 1 edge), tdata = captured count.
//   A wrap request bumps a saturating wrap count; an edge request closes a
//   period from the previous capture, the current one and the wraps between.
//   Every request gives one result: period in ticks, in ns, frequency in mHz,
//   and in tuser a flag set when the wrap count had saturated.
//   cfg_wr_en_i/cfg_wr_data_i write the timer clock in MHz (reset 48); write
//   only while no request is in flight.
//   Timing: one shared divider produces one quotient bit per cycle. The ns
//   value takes 50 steps, the frequency 38; a result is valid after setup,
//   both divisions and capture, and the next request is accepted once the
//   sequencer is idle again. A zero period skips the frequency division, a
//   zero clock register skips both.
//   s_axis_tready_o is high only while the sequencer is idle.
//   The result sits in an output register; a new request is accepted while it
//   waits, and the sequencer holds its finished result until that register
//   frees up, so a stalled receiver stalls the input after one request.
//   Reset clears all state, restores the clock register and empties output.
module edge_period_frequency_meter #(
  parameter int COUNTER_BITS = epfm_pkg::COUNTER_BITS_DEF,
  parameter int WRAP_BITS    = epfm_pkg::WRAP_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic [7:0]   cfg_wr_data_i,   // timer_clock_mhz
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,  // [31:0] captured_count
  input  logic         s_axis_tuser_i,  // [0] command
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [39:0] period_counts, [89:40] period_ns, [127:90] frequency_mhz_milli
  output logic [127:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o   // [0] wraps_saturated
);

  localparam int PER_W = epfm_pkg::PER_W;
  localparam int NS_W  = epfm_pkg::NS_W;
  localparam int FQ_W  = epfm_pkg::FQ_W;
  localparam int NUM_W = epfm_pkg::DIV_NUM_W;
  localparam int DEN_W = epfm_pkg::DIV_DEN_W;
  localparam int CNT_W = epfm_pkg::DIV_CNT_W;
  localparam int SUM_W = (COUNTER_BITS + WRAP_BITS > PER_W) ?
                         (COUNTER_BITS + WRAP_BITS) : PER_W;
  localparam logic [WRAP_BITS-1:0] WRAP_MAX = {WRAP_BITS{1'b1}};

  epfm_pkg::epfm_ctrl_t ctrl;
  epfm_pkg::epfm_stat_t stat;

  logic [epfm_pkg::CLK_W-1:0] clk_mhz_q;
  logic [COUNTER_BITS-1:0]    last_cap_q;
  logic [WRAP_BITS-1:0]       wrap_q;
  logic [PER_W-1:0]           period_q;
  logic                       sat_q;
  logic [NS_W-1:0]            ns_q;
  logic [FQ_W-1:0]            fq_q;

  logic                       m_valid_q;
  logic [PER_W-1:0]           m_per_q;
  logic [NS_W-1:0]            m_ns_q;
  logic [FQ_W-1:0]            m_fq_q;
  logic                       m_sat_q;

  logic                       in_fire;
  logic [COUNTER_BITS-1:0]    cap;
  logic [COUNTER_BITS-1:0]    diff;
  logic [SUM_W-1:0]           per_sum;
  logic [NS_W-1:0]            ns_num;
  logic [FQ_W-1:0]            fq_num;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic [CNT_W-1:0]           div_steps;
  logic [NUM_W-1:0]           div_quot;
  logic                       div_done;

  assign in_fire = s_axis_tvalid_i && ctrl.in_ready;
  assign s_axis_tready_o = ctrl.in_ready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_mhz_q <= epfm_pkg::CLK_MHZ_RESET;
    end else if (cfg_wr_en_i) begin
      clk_mhz_q <= cfg_wr_data_i;
    end
  end

  // Period from previous and current capture plus whole wraps
  assign cap     = s_axis_tdata_i[COUNTER_BITS-1:0];
  assign diff    = last_cap_q - cap;
  assign per_sum = SUM_W'(diff) + (SUM_W'(wrap_q) << COUNTER_BITS);

  // Measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cap_q <= '0;
      wrap_q     <= '0;
      period_q   <= '0;
      sat_q      <= 1'b0;
    end else if (in_fire) begin
      if (s_axis_tuser_i == epfm_pkg::CMD_WRAP) begin
        if (wrap_q != WRAP_MAX) wrap_q <= wrap_q + 1'b1;
        sat_q <= (wrap_q >= WRAP_MAX - 1'b1);
      end else begin
        sat_q      <= (wrap_q == WRAP_MAX);
        period_q   <= per_sum[PER_W-1:0];
        wrap_q     <= '0;
        last_cap_q <= cap;
      end
    end
  end

  // Dividends: period*1000 as shifts and adds, clock*1e9 by a constant
  assign ns_num = (NS_W'(period_q) << 10) - (NS_W'(period_q) << 5)
                + (NS_W'(period_q) << 3);
  assign fq_num = FQ_W'(clk_mhz_q) * epfm_pkg::MILLIHZ_PER_MHZ;

  // Shared divider operand select
  always_comb begin
    if (ctrl.div_fq) begin
      div_num   = {fq_num, {(NUM_W - FQ_W){1'b0}}};
      div_den   = DEN_W'(period_q);
      div_steps = CNT_W'(FQ_W);
    end else begin
      div_num   = ns_num;
      div_den   = DEN_W'(clk_mhz_q);
      div_steps = CNT_W'(NS_W);
    end
  end

  epfm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  // Sequencer status
  always_comb begin
    stat          = '0;
    stat.in_fire  = in_fire;
    stat.div_done = div_done;
    stat.clk_zero = (clk_mhz_q == '0);
    stat.per_zero = (period_q == '0);
    stat.out_free = !m_valid_q || m_axis_tready_i;
  end

  epfm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Quotient capture
  always_ff @(posedge clk_i) begin
    if (ctrl.clr_res) begin
      ns_q <= '0;
      fq_q <= '0;
    end else begin
      if (ctrl.cap_ns) ns_q <= div_quot[NS_W-1:0];
      if (ctrl.cap_fq) fq_q <= div_quot[FQ_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      m_per_q <= period_q;
      m_ns_q  <= ns_q;
      m_fq_q  <= fq_q;
      m_sat_q <= sat_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_fq_q, m_ns_q, m_per_q};
  assign m_axis_tuser_o  = m_sat_q;

endmodule

// ----- rtl/epfm_checker.sv -----
// Port-level checker for the edge period and frequency meter, with its bind.
// Depends on edge_period_frequency_meter port names only.
`timescale 1ns / 1ps

module epfm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // An accepted request keeps the input closed through ST_NS_GO and the state after it
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input reopened too early");

  // Zero period gives zero frequency
  a_zero_per_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[39:0] == 40'd0)) |->
      (m_axis_tdata_o[127:90] == 38'd0))
    else $error("nonzero frequency for zero period");

  // Zero period gives zero ns
  a_zero_per_ns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[39:0] == 40'd0)) |->
      (m_axis_tdata_o[89:40] == 50'd0))
    else $error("nonzero ns for zero period");

endmodule

bind edge_period_frequency_meter epfm_checker u_epfm_checker (.*);

// ----- tb/tb_edge_period_frequency_meter.sv -----
// Self-checking testbench for the edge period and frequency meter.
// Streams wrap and edge requests, predicts every reading and checks it.
// Depends on epfm_pkg and edge_period_frequency_meter.
`timescale 1ns / 1ps

// Wrap count level at which it stops counting
localparam logic [7:0] WRAP_SAT_LEVEL = 8'((1 << epfm_pkg::WRAP_BITS_DEF) - 1);
localparam logic [63:0] NS_PER_US = 64'd1000;

// One reading as it leaves the meter
typedef struct packed {
  logic [39:0] period_counts;
  logic [49:0] period_ns;
  logic [37:0] freq_millihz;
  logic        wraps_sat;
} meter_reading_t;

// Tracks the meter state, predicts readings and checks them in order
class meter_readings;
  logic [7:0]     clock_mhz;
  logic [31:0]    prev_capture;
  logic [7:0]     wrap_tally;
  logic [39:0]    period;
  meter_reading_t awaited_q[$];
  int             errors;
  int             readings_checked;
  int             edges_seen;
  int             sat_flags_seen;

  function new();
    clock_mhz        = epfm_pkg::CLK_MHZ_RESET;
    prev_capture     = '0;
    wrap_tally       = '0;
    period           = '0;
    errors           = 0;
    readings_checked = 0;
    edges_seen       = 0;
    sat_flags_seen   = 0;
  endfunction

  function void set_clock(logic [7:0] mhz);
    clock_mhz = mhz;
  endfunction

  function int outstanding();
    return awaited_q.size();
  endfunction

  // Update the meter state for an accepted request and queue its reading
  function void note_request(logic cmd, logic [31:0] capture);
    meter_reading_t rd;
    logic [63:0] ns_wide;
    logic [63:0] fq_wide;
    if (cmd == epfm_pkg::CMD_WRAP) begin
      if (wrap_tally != WRAP_SAT_LEVEL) wrap_tally++;
      rd.wraps_sat = (wrap_tally == WRAP_SAT_LEVEL);
    end else begin
      rd.wraps_sat = (wrap_tally == WRAP_SAT_LEVEL);
      // wraps above the modular capture difference, kept to 40 bits
      period       = {wrap_tally, 32'(prev_capture - capture)};
      wrap_tally   = '0;
      prev_capture = capture;
      edges_seen++;
    end
    ns_wide = '0;
    fq_wide = '0;
    if (clock_mhz != 0) begin
      ns_wide = (64'(period) * NS_PER_US) / 64'(clock_mhz);
      if (period != 0)
        fq_wide = (64'(clock_mhz) * 64'(epfm_pkg::MILLIHZ_PER_MHZ)) / 64'(period);
    end
    rd.period_counts = period;
    rd.period_ns     = ns_wide[49:0];
    rd.freq_millihz  = fq_wide[37:0];
    awaited_q.push_back(rd);
  endfunction

  function void report(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // Compare an accepted reading with the oldest prediction
  function void check_result(logic [127:0] data, logic usr);
    meter_reading_t want;
    if (awaited_q.size() == 0) begin
      $display("%0t ns: unexpected reading, expected none, got data %h flag %b",
               $time, data, usr);
      errors++;
      return;
    end
    want = awaited_q.pop_front();
    report("period_counts", 64'(want.period_counts), 64'(data[39:0]));
    report("period_ns", 64'(want.period_ns), 64'(data[89:40]));
    report("frequency_mhz_milli", 64'(want.freq_millihz), 64'(data[127:90]));
    report("wraps_saturated", 64'(want.wraps_sat), 64'(usr));
    if (usr === 1'b1) sat_flags_seen++;
    readings_checked++;
  endfunction
endclass

module tb_edge_period_frequency_meter;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_wr_en;
  logic [7:0]   cfg_wr_data;
  logic         s_valid;
  logic         s_ready;
  logic [31:0]  s_tdata;  // [31:0] captured_count
  logic         s_tuser;  // [0] command
  logic         m_valid;
  logic         m_tready;
  logic [127:0] m_tdata;  // [39:0] period, [89:40] ns, [127:90] millihertz
  logic         m_tuser;  // [0] wraps_saturated

  meter_readings sb;
  logic [31:0]   gen_last_cap;
  int            tx_gap;
  bit            tx_burst;
  int            idle_cycles;
  int            clock_settings;

  edge_period_frequency_meter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Reading side: random stalls with occasional stall-free bursts
  initial begin
    int stall;
    int burst_left;
    burst_left = 0;
    m_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (burst_left == 0 && $urandom_range(0, 4) == 0) burst_left = $urandom_range(5, 30);
      if (burst_left > 0) begin
        stall = 0;
        burst_left--;
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_valid && m_tready));
    end
  end

  // Check every accepted reading
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog on cycles with no request or reading moving
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_valid && s_ready) || (m_valid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Send one request; valid stays high when the next one follows at once
  task automatic send_request(input logic cmd, input logic [31:0] cap);
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk_i);
    s_valid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= cap;
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(cmd, cap);
    if (cmd == epfm_pkg::CMD_EDGE) gen_last_cap = cap;
    tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (tx_gap != 0) s_valid <= 1'b0;
  endtask

  // Stop the stream and wait for every reading to come back
  task automatic drain_readings();
    if (tx_gap == 0) begin
      s_valid <= 1'b0;
      tx_gap = 1;
    end
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_clock(input logic [7:0] mhz);
    drain_readings();
    @(posedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mhz;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    sb.set_clock(mhz);
    clock_settings++;
  endtask

  // Runs of wraps closed by an edge; the capture is sometimes chosen to
  // give a zero, tiny or maximal modular difference
  task automatic run_random(input int n_items, input bit force_long);
    int sent;
    int runlen;
    int pick;
    logic [31:0] cap;
    bit first;
    sent  = 0;
    first = 1'b1;
    while (sent < n_items) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (first && force_long) runlen = $urandom_range(255, 262);
      else if (pick < 45) runlen = 0;
      else if (pick < 85) runlen = $urandom_range(1, 4);
      else if (pick < 97) runlen = $urandom_range(5, 30);
      else runlen = $urandom_range(250, 262);
      repeat (runlen) send_request(epfm_pkg::CMD_WRAP, $urandom);
      case ($urandom_range(0, 9))
        0: cap = gen_last_cap;
        1: cap = gen_last_cap - 32'd1;
        2: cap = gen_last_cap + 32'd1;
        default: cap = $urandom;
      endcase
      if (first && force_long) cap = gen_last_cap + 32'd1;
      send_request(epfm_pkg::CMD_EDGE, cap);
      sent += runlen + 1;
      first = 1'b0;
    end
  endtask

  initial begin
    sb             = new();
    gen_last_cap   = '0;
    tx_gap         = 1;
    tx_burst       = 1'b0;
    clock_settings = 1;
    rst_ni      <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_valid     <= 1'b0;
    s_tuser     <= epfm_pkg::CMD_WRAP;
    s_tdata     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first edge against a zero capture, extreme differences,
    // wraps with junk data, a zero period
    send_request(epfm_pkg::CMD_EDGE, 32'h0000_0000);
    send_request(epfm_pkg::CMD_EDGE, 32'hFFFF_FFFF);
    send_request(epfm_pkg::CMD_EDGE, 32'h0000_0000);
    send_request(epfm_pkg::CMD_WRAP, 32'hFFFF_FFFF);
    send_request(epfm_pkg::CMD_WRAP, 32'h0000_0000);
    send_request(epfm_pkg::CMD_EDGE, 32'h8000_0000);
    send_request(epfm_pkg::CMD_EDGE, 32'h8000_0000);
    send_request(epfm_pkg::CMD_WRAP, 32'h5A5A_A5A5);
    send_request(epfm_pkg::CMD_EDGE, 32'h7FFF_FFFF);
    send_request(epfm_pkg::CMD_EDGE, 32'h5555_5555);
    send_request(epfm_pkg::CMD_EDGE, 32'hAAAA_AAAA);

    // Fastest clock with a saturated wrap count and the widest period
    write_clock(8'd255);
    run_random(120, 1'b1);
    write_clock(8'd1);
    run_random(120, 1'b0);
    // Zero clock register: conversions read as zero
    write_clock(8'd0);
    run_random(60, 1'b0);
    repeat (3) begin
      write_clock(8'($urandom_range(1, 254)));
      run_random(100, 1'b0);
    end

    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d readings (%0d edges, %0d saturated flags) over %0d clock settings.",
             sb.readings_checked, sb.edges_seen, sb.sat_flags_seen, clock_settings);
    $display("Mismatches and unexpected readings: %0d, readings still awaited: %0d.",
             sb.errors, sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
